// ===== design/mma_pkg.sv =====
// Package for the MIDI message assembler with echo.
// Holds the message descriptor type, the kind codes and the MIDI status constants.
// No dependencies.
package mma_pkg;

	localparam logic [1:0] KIND_CHANNEL  = 2'd0;
	localparam logic [1:0] KIND_COMMON   = 2'd1;
	localparam logic [1:0] KIND_REALTIME = 2'd2;

	localparam logic [7:0] REALTIME_MIN = 8'hF8;
	localparam logic [7:0] SYSTEM_MIN   = 8'hF0;
	localparam logic [3:0] HI_PROG      = 4'hC;
	localparam logic [3:0] HI_PRESS     = 4'hD;
	localparam logic [3:0] HI_SYSTEM    = 4'hF;
	localparam logic [7:0] ST_MTC       = 8'hF1;
	localparam logic [7:0] ST_SONG_POS  = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
	localparam logic [7:0] ST_TUNE      = 8'hF6;

	localparam int QUEUE_DEPTH = 2;

	// One complete message to be echoed, from status byte to last data byte.
	typedef struct packed {
		logic [7:0] status;
		logic [6:0] d0;
		logic [6:0] d1;
		logic [1:0] len;
		logic [1:0] kind;
	} desc_t;

endpackage

// ===== design/mma_front.sv =====
// Front part of the MIDI message assembler: parses received bytes and
// emits one descriptor for each completed message. Depends on mma_pkg.
module mma_front import mma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       emit,
	output desc_t      desc
);

	logic [7:0] cur_status_q, cur_status_d;
	logic [1:0] need_q, need_d;
	logic       cnt_q, cnt_d;
	logic [6:0] store_q, store_d;
	logic [1:0] status_need;
	logic       msg_kind;

	// Message length that a status byte opens.
	always_comb begin
		priority if (rx_byte[7:4] == HI_PROG || rx_byte[7:4] == HI_PRESS) begin
			status_need = 2'd2;
		end else if (rx_byte[7:4] == HI_SYSTEM) begin
			priority if (rx_byte == ST_MTC || rx_byte == ST_SONG_SEL) begin
				status_need = 2'd2;
			end else if (rx_byte == ST_SONG_POS) begin
				status_need = 2'd3;
			end else if (rx_byte == ST_TUNE) begin
				status_need = 2'd1;
			end else begin
				status_need = 2'd0;
			end
		end else begin
			status_need = 2'd3;
		end
	end

	assign msg_kind = (cur_status_q >= SYSTEM_MIN);

	always_comb begin
		cur_status_d = cur_status_q;
		need_d       = need_q;
		cnt_d        = cnt_q;
		store_d      = store_q;
		emit         = 1'b0;
		desc         = '0;
		if (accept) begin
			priority if (rx_byte >= REALTIME_MIN) begin
				emit        = 1'b1;
				desc.status = rx_byte;
				desc.len    = 2'd1;
				desc.kind   = KIND_REALTIME;
			end else if (rx_byte[7]) begin
				cur_status_d = rx_byte;
				cnt_d        = 1'b0;
				if (status_need == 2'd1) begin
					emit        = 1'b1;
					desc.status = rx_byte;
					desc.len    = 2'd1;
					desc.kind   = KIND_COMMON;
					need_d      = 2'd0;
				end else begin
					need_d = status_need;
				end
			end else if (need_q != 2'd0) begin
				if (need_q == 2'd2 || cnt_q) begin
					// This data byte completes the message.
					emit        = 1'b1;
					desc.status = cur_status_q;
					desc.len    = need_q;
					desc.kind   = msg_kind ? KIND_COMMON : KIND_CHANNEL;
					desc.d0     = (need_q == 2'd2) ? rx_byte[6:0] : store_q;
					desc.d1     = rx_byte[6:0];
					cnt_d       = 1'b0;
					if (msg_kind) begin
						need_d = 2'd0;
					end
				end else begin
					store_d = rx_byte[6:0];
					cnt_d   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_status_q <= '0;
			need_q       <= '0;
			cnt_q        <= 1'b0;
		end else begin
			cur_status_q <= cur_status_d;
			need_q       <= need_d;
			cnt_q        <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		store_q <= store_d;
	end

endmodule

// ===== design/mma_queue.sv =====
// Two-entry descriptor queue between the parser and the echo sequencer.
// Depends on mma_pkg.
module mma_queue import mma_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  desc_t wr_data,
	output logic  full,
	input  logic  rd_en,
	output logic  rd_valid,
	output desc_t rd_data
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	desc_t            mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full     = (count_q == CntW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== design/mma_back.sv =====
// Back part of the MIDI message assembler: walks each descriptor one beat
// per cycle into the output register, while that register is empty or being popped. Depends on mma_pkg.
module mma_back import mma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  desc_t      q_data,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] echo_byte,
	output logic       last,
	output logic [1:0] kind
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] echo_q;
	logic       last_q;
	logic [1:0] kind_q;
	logic       load;
	logic       beat_last;
	logic [7:0] beat_byte;

	assign load      = q_valid && (!out_valid_q || pop);
	assign beat_last = (idx_q == q_data.len - 2'd1);
	assign q_pop     = load && beat_last;

	always_comb begin
		unique case (idx_q)
			2'd0:    beat_byte = q_data.status;
			2'd1:    beat_byte = {1'b0, q_data.d0};
			2'd2:    beat_byte = {1'b0, q_data.d1};
			default: beat_byte = q_data.status;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= beat_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			echo_q <= beat_byte;
			last_q <= beat_last;
			kind_q <= q_data.kind;
		end
	end

	assign empty     = !out_valid_q;
	assign echo_byte = echo_q;
	assign last      = last_q;
	assign kind      = kind_q;

endmodule

// ===== design/midi_message_assembler_echo_unit.sv =====
// MIDI message assembler with echo: a byte that completes a message has its descriptor
// registered in the queue, and the first beat of its echo is then registered into the output.
// A message of n bytes (one to three) leaves at one beat per cycle while the consumer pops
// or the output is empty; a byte that completes nothing is still accepted while the queue
// has room. Reset (arst_n low) clears the parser state, the queue and the output.
// Depends on mma_pkg, mma_front, mma_queue and mma_back.
module midi_message_assembler_echo_unit import mma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] echo_byte,
	output logic       last,
	output logic [1:0] kind
);

	// A byte is taken whenever the descriptor queue has room, even if it
	// completes nothing, which keeps the accept condition independent of data.
	logic  accept;
	logic  emit;
	desc_t front_desc;
	logic  q_valid;
	logic  q_pop;
	desc_t q_data;

	assign accept = push && !full;

	// The parser keeps the current status, the first data byte and the
	// message length; running status is simply the current status staying
	// open after a channel message completes.
	mma_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.emit    (emit),
		.desc    (front_desc)
	);

	// The queue lets the parser keep accepting bytes while the sequencer
	// is still sending earlier messages or the consumer stalls.
	mma_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (emit),
		.wr_data  (front_desc),
		.full     (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	// The sequencer sends the status byte first, then the data bytes, and
	// marks the final beat of each message.
	mma_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.echo_byte (echo_byte),
		.last      (last),
		.kind      (kind)
	);

endmodule
